// ===== rtl/core/set_assoc_lru_cache_tags_top_assert.svh =====
// assertion macros for the cache tag store
// used by the back end; no other dependencies
`ifndef SET_ASSOC_LRU_CACHE_TAGS_TOP_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_TOP_ASSERT_SVH
`ifndef SYNTH
`define SALC_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define SALC_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define SALC_ASSERT_IMP(label, clk, rst, a, c, msg)
`define SALC_ASSERT_NXT(label, clk, rst, a, c, msg)
`endif
`endif

// ===== rtl/core/salc_pkg.sv =====
// shared types and constants for the cache tag store
// no dependencies
`default_nettype none
package salc_pkg;
  localparam int NUM_WAYS_DEF = 2;
  localparam int MAX_SETS_DEF = 256;
  localparam int ADDRESS_BITS_DEF = 48;
  localparam int CNT_W = 48;
  localparam int TAG_W = 48;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic [3:0] SEL_ACCESS = 4'd0;
  localparam logic [3:0] SEL_MISS   = 4'd1;
  localparam logic [3:0] SEL_CHIT   = 4'd2;
  localparam logic [3:0] SEL_DHIT   = 4'd3;
  localparam logic [3:0] SEL_CREPL  = 4'd4;
  localparam logic [3:0] SEL_DREPL  = 4'd5;
  localparam logic [3:0] SEL_WB     = 4'd6;
  localparam logic [3:0] SEL_POS    = 4'd7;

  localparam logic [0:0] REG_OFFSET = 1'd0;
  localparam logic [0:0] REG_INDEX  = 1'd1;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/set_assoc_lru_cache_tags_top.sv =====
// top level of the set-associative lru cache tag store
// depends on salc_pkg, salc_front, salc_back
//
// channel   | handshake      | payload
// input     | push / full    | action, address, counter_select
// result    | pop / empty    | hit .. counter_value
// config    | cfg_we         | cfg_index, cfg_data
//
// an access holds the back end through take with tag read, then
// compare, write of tag, valid, dirty and rank, and result push; a query or
// unused action pushes its result at take. the back end takes a transaction
// only while the result queue is empty or holds one result being popped.
// after reset a pass over all MAX_SETS sets sets the ranks and clears valid
// and dirty; no item is taken meanwhile, so the two-entry request queue fills and push stalls.
`default_nettype none
module set_assoc_lru_cache_tags_top import salc_pkg::*; #(
  parameter int NUM_WAYS = NUM_WAYS_DEF,
  parameter int MAX_SETS = MAX_SETS_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic full,
  input  wire logic [1:0] action,
  input  wire logic [ADDRESS_BITS-1:0] address,
  input  wire logic [3:0] counter_select,
  output logic empty,
  input  wire logic pop,
  output logic hit,
  output logic hit_was_dirty,
  output logic [$clog2(NUM_WAYS)-1:0] way_used,
  output logic [$clog2(NUM_WAYS)-1:0] hit_stack_position,
  output logic replaced_valid,
  output logic writeback_needed,
  output logic [CNT_W-1:0] counter_value,
  input  wire logic cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [3:0] cfg_data
);
  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  logic [3:0] offset_bit_count, index_bit_count;
  logic q_valid, q_take;
  logic [1:0] q_action;
  logic [SET_W-1:0] q_set;
  logic [TAG_W-1:0] q_tag;
  logic [3:0] q_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bit_count <= 4'd6;
      index_bit_count <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET: offset_bit_count <= cfg_data;
        REG_INDEX:  index_bit_count <= cfg_data;
        default: ;
      endcase
    end
  end

  salc_front #(.MAX_SETS(MAX_SETS), .ADDRESS_BITS(ADDRESS_BITS)) u_front (
    .clk, .rst, .push, .full, .action, .address, .counter_select,
    .ofs_count(offset_bit_count), .idx_count(index_bit_count),
    .q_valid, .q_take, .q_action, .q_set, .q_tag, .q_sel
  );

  salc_back #(.NUM_WAYS(NUM_WAYS), .MAX_SETS(MAX_SETS)) u_back (
    .clk, .rst, .q_valid, .q_take, .q_action, .q_set, .q_tag, .q_sel,
    .empty, .pop, .hit, .hit_was_dirty, .way_used, .hit_stack_position,
    .replaced_valid, .writeback_needed, .counter_value
  );
endmodule
`default_nettype wire

// ===== rtl/core/salc_front.sv =====
// front end: splits address into set and tag, queues classified requests
// depends on salc_pkg
`default_nettype none
module salc_front import salc_pkg::*; #(
  parameter int MAX_SETS = MAX_SETS_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
  parameter int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic full,
  input  wire logic [1:0] action,
  input  wire logic [ADDRESS_BITS-1:0] address,
  input  wire logic [3:0] counter_select,
  input  wire logic [3:0] ofs_count,
  input  wire logic [3:0] idx_count,
  output logic q_valid,
  input  wire logic q_take,
  output logic [1:0] q_action,
  output logic [SET_W-1:0] q_set,
  output logic [TAG_W-1:0] q_tag,
  output logic [3:0] q_sel
);
  localparam int MAXIB = $clog2(MAX_SETS + 1) - 1;
  localparam int DEPTH = 2;
  logic [1:0] f_act [DEPTH];
  logic [SET_W-1:0] f_set [DEPTH];
  logic [TAG_W-1:0] f_tag [DEPTH];
  logic [3:0] f_sel [DEPTH];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic [4:0] ib;
  logic [63:0] shifted, tag_full;
  logic [SET_W-1:0] set_val;

  always_comb begin
    ib = (idx_count > 4'(MAXIB)) ? 5'(MAXIB) : {1'b0, idx_count};
    shifted = 64'(address) >> ofs_count;
    set_val = SET_W'(shifted & ((64'd1 << ib) - 64'd1));
    tag_full = shifted >> ib;
  end

  assign full = (count == 2'(DEPTH));
  assign q_valid = (count != 2'd0);
  assign q_action = f_act[rd_ptr];
  assign q_set = f_set[rd_ptr];
  assign q_tag = f_tag[rd_ptr];
  assign q_sel = f_sel[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      f_act[wr_ptr] <= action;
      f_set[wr_ptr] <= set_val;
      f_tag[wr_ptr] <= tag_full[TAG_W-1:0];
      f_sel[wr_ptr] <= counter_select;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (q_take && q_valid) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push && !full) - 2'(q_take && q_valid);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/salc_back.sv =====
// back end: tag memory read, compare, lru update, statistics, result queue
// depends on salc_pkg and the assertion macro header
`default_nettype none
`include "set_assoc_lru_cache_tags_top_assert.svh"
module salc_back import salc_pkg::*; #(
  parameter int NUM_WAYS = NUM_WAYS_DEF,
  parameter int MAX_SETS = MAX_SETS_DEF,
  parameter int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
  parameter int WAY_W = $clog2(NUM_WAYS)
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  output logic q_take,
  input  wire logic [1:0] q_action,
  input  wire logic [SET_W-1:0] q_set,
  input  wire logic [TAG_W-1:0] q_tag,
  input  wire logic [3:0] q_sel,
  output logic empty,
  input  wire logic pop,
  output logic hit,
  output logic hit_was_dirty,
  output logic [WAY_W-1:0] way_used,
  output logic [WAY_W-1:0] hit_stack_position,
  output logic replaced_valid,
  output logic writeback_needed,
  output logic [CNT_W-1:0] counter_value
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_INIT = 2'd2;
  localparam int RES_W = 4 + 2 * WAY_W + CNT_W;

  // tag, valid, dirty and rank per way; the pass after reset sets ranks
  // and clears valid and dirty
  logic [TAG_W-1:0] tag_mem [NUM_WAYS][MAX_SETS];
  logic [WAY_W-1:0] rank_mem [NUM_WAYS][MAX_SETS];
  logic dirty_mem [NUM_WAYS][MAX_SETS];
  logic valid_mem [NUM_WAYS][MAX_SETS];
  logic [TAG_W-1:0] rd_tag [NUM_WAYS];
  logic [WAY_W-1:0] rd_rank [NUM_WAYS];
  logic rd_dirty [NUM_WAYS];
  logic [NUM_WAYS-1:0] rd_valid;

  logic [1:0] state, state_next;
  logic [SET_W-1:0] init_idx;
  logic [1:0] cur_act;
  logic [SET_W-1:0] cur_set;
  logic [TAG_W-1:0] cur_tag;

  logic [CNT_W-1:0] c_acc, c_miss, c_chit, c_dhit, c_crep, c_drep, c_wb;
  logic [CNT_W-1:0] c_pos [NUM_WAYS];

  // result fifo, two deep
  logic [RES_W-1:0] rq [2];
  logic rq_wp, rq_rp;
  logic [1:0] rq_cnt;
  logic res_push;
  logic [RES_W-1:0] res_data;

  logic found, rv, wb, pdirty;
  logic [WAY_W-1:0] hway, vway, uway, pos;
  logic [CNT_W-1:0] qval;

  assign empty = (rq_cnt == 2'd0);
  assign {hit, hit_was_dirty, way_used, hit_stack_position,
          replaced_valid, writeback_needed, counter_value} = rq[rq_rp];

  // fifo room is checked at take time so one result slot is always free
  assign q_take = (state == ST_IDLE) && q_valid && (rq_cnt < 2'd2) &&
                  !(rq_cnt == 2'd1 && !pop);

  always_comb begin
    found = 1'b0;
    hway = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (rd_valid[w] && rd_tag[w] == cur_tag) begin
        found = 1'b1;
        hway = WAY_W'(w);
      end
    end
    vway = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (rd_rank[w] == '0) vway = WAY_W'(w);
    end
    uway = found ? hway : vway;
    pos = rd_rank[uway];
    pdirty = rd_dirty[uway];
    rv = !found && rd_valid[vway];
    wb = rv && rd_dirty[vway];
  end

  always_comb begin
    unique case (q_sel)
      SEL_ACCESS: qval = c_acc;
      SEL_MISS:   qval = c_miss;
      SEL_CHIT:   qval = c_chit;
      SEL_DHIT:   qval = c_dhit;
      SEL_CREPL:  qval = c_crep;
      SEL_DREPL:  qval = c_drep;
      SEL_WB:     qval = c_wb;
      default: begin
        qval = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (q_sel >= SEL_POS && 32'(q_sel - SEL_POS) == w) qval = c_pos[w];
        end
      end
    endcase
  end

  always_comb begin
    state_next = state;
    res_push = 1'b0;
    res_data = '0;
    unique case (state)
      ST_INIT: if (init_idx == SET_W'(MAX_SETS - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (q_take) begin
          if (q_action == ACT_READ || q_action == ACT_WRITE) begin
            state_next = ST_LOOK;
          end else begin
            res_push = 1'b1;
            res_data = {4'b0, {(2 * WAY_W){1'b0}},
                        (q_action == ACT_QUERY) ? qval : {CNT_W{1'b0}}};
          end
        end
      end
      ST_LOOK: begin
        res_push = 1'b1;
        res_data = {found, found && pdirty, uway, found ? pos : {WAY_W{1'b0}},
                    rv, wb, {CNT_W{1'b0}}};
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (state == ST_INIT) begin
        rank_mem[w][init_idx] <= WAY_W'(w);
        valid_mem[w][init_idx] <= 1'b0;
        dirty_mem[w][init_idx] <= 1'b0;
      end else if (state == ST_IDLE && q_take) begin
        rd_tag[w] <= tag_mem[w][q_set];
        rd_rank[w] <= rank_mem[w][q_set];
        rd_dirty[w] <= dirty_mem[w][q_set];
        rd_valid[w] <= valid_mem[w][q_set];
      end else if (state == ST_LOOK) begin
        if (WAY_W'(w) == uway) begin
          rank_mem[w][cur_set] <= WAY_W'(NUM_WAYS - 1);
          valid_mem[w][cur_set] <= 1'b1;
          if (!found) begin
            tag_mem[w][cur_set] <= cur_tag;
            dirty_mem[w][cur_set] <= 1'b0;
          end else if (cur_act == ACT_WRITE) begin
            dirty_mem[w][cur_set] <= 1'b1;
          end
        end else if (rd_rank[w] > pos) begin
          rank_mem[w][cur_set] <= rd_rank[w] - WAY_W'(1);
        end
      end
    end
    if (state == ST_IDLE && q_take) begin
      cur_act <= q_action;
      cur_set <= q_set;
      cur_tag <= q_tag;
    end
    if (res_push) rq[rq_wp] <= res_data;
    if (rst) begin
      state <= ST_INIT;
      init_idx <= '0;
      rq_wp <= 1'b0;
      rq_rp <= 1'b0;
      rq_cnt <= 2'd0;
      c_acc <= '0; c_miss <= '0; c_chit <= '0; c_dhit <= '0;
      c_crep <= '0; c_drep <= '0; c_wb <= '0;
      for (int w = 0; w < NUM_WAYS; w++) c_pos[w] <= '0;
    end else begin
      state <= state_next;
      if (state == ST_INIT) init_idx <= init_idx + SET_W'(1);
      if (res_push) rq_wp <= ~rq_wp;
      if (pop && !empty) rq_rp <= ~rq_rp;
      rq_cnt <= rq_cnt + 2'(res_push) - 2'(pop && !empty);
      if (state == ST_LOOK) begin
        c_acc <= sat_inc(c_acc);
        if (found) begin
          if (pdirty) c_dhit <= sat_inc(c_dhit);
          else c_chit <= sat_inc(c_chit);
          c_pos[pos] <= sat_inc(c_pos[pos]);
        end else begin
          c_miss <= sat_inc(c_miss);
          if (wb) begin
            c_drep <= sat_inc(c_drep);
            c_wb <= sat_inc(c_wb);
          end else if (rv) begin
            c_crep <= sat_inc(c_crep);
          end
        end
      end
    end
  end

  `SALC_ASSERT_NXT(a_look_one, clk, rst, state == ST_LOOK, state == ST_IDLE, "lookup stuck")
  `SALC_ASSERT_IMP(a_no_ovf, clk, rst, res_push, rq_cnt != 2'd2 || pop, "result fifo overflow")
  `SALC_ASSERT_IMP(a_take_idle, clk, rst, q_take, state == ST_IDLE, "take while busy")
  `SALC_ASSERT_IMP(a_wb_miss, clk, rst, res_push && res_data[RES_W-1],
                   !res_data[CNT_W], "writeback on hit")
endmodule
`default_nettype wire
